// ===== hw/rtl/rbs_pkg.sv =====
package rbs_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int EPS_WIDTH   = 16;
  localparam int NUM_AXES    = 3;

  // dividend is |num| << FRAC_BITS, one quotient bit per stage
  localparam int DIV_STAGES  = COORD_WIDTH + FRAC_BITS;
  localparam int DIVD_WIDTH  = COORD_WIDTH + FRAC_BITS;

  // config bus geometry
  localparam int CFG_DW      = (COORD_WIDTH > 32) ? 64 : 32;
  localparam int REG_SHIFT   = (COORD_WIDTH > 32) ? 3 : 2;
  localparam int REG_IDX_W   = 3;
  localparam int PADDR_W     = REG_SHIFT + REG_IDX_W;

  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_HIT_EPS   = 3'd6;

  localparam logic [EPS_WIDTH-1:0] EPS_RESET = EPS_WIDTH'(7);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic        [COORD_WIDTH-1:0] mag_t;

  localparam coord_t T_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t T_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
  } in_word_t;

  typedef struct packed {
    logic   hit_flag;
    coord_t t_enter_out;
    coord_t t_exit_out;
  } out_word_t;

  // one axis after slab set-up, ready for the dividers
  typedef struct packed {
    mag_t n_ent;
    mag_t n_ext;
    mag_t m;
    logic neg_ent;
    logic neg_ext;
    logic dzero;
    logic in_slab;
  } prep_axis_t;

  // control travelling beside the dividers
  typedef struct packed {
    logic                valid;
    logic [NUM_AXES-1:0] dzero;
    logic [NUM_AXES-1:0] in_slab;
  } side_t;

endpackage

// ===== hw/rtl/ray_box_slab_intersect.sv =====
// ray versus axis-aligned box, slab test, one ray per clock
//
// input: present a ray on in_word with start high; it is taken at any edge
// where start is high and busy is low. busy stays low, so a ray can be
// offered every cycle.
// result: out_strobe is high for exactly one cycle with out_word holding
// hit_flag and the entry and exit parameters (zero on a miss). results come
// out in input order, one per ray.
// pipeline: the prep register, then the stages of the six dividers, which
// form one quotient bit per pipeline stage, then the slab and output
// registers of the reduce block.
// throughput: one ray per cycle, fully pipelined, no stall path.
// config: box corners and hit_epsilon over the apb-style port, written while
// no ray is in flight; reads return the stored value.
// reset: rst_n (synchronous) empties the pipeline, clears the box to zero
// and sets hit_epsilon to 7. the receiver cannot hold results off.
module ray_box_slab_intersect import rbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_word_t           in_word,
  output logic               out_strobe,
  output out_word_t          out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready
);

  coord_t [NUM_AXES-1:0] box_min_r;
  coord_t [NUM_AXES-1:0] box_max_r;
  logic [EPS_WIDTH-1:0]  eps_r;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_wr;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = paddr[PADDR_W-1:REG_SHIFT];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_min_r <= '0;
      box_max_r <= '0;
      eps_r     <= EPS_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BOX_MIN_X: box_min_r[0] <= pwdata[COORD_WIDTH-1:0];
        REG_BOX_MIN_Y: box_min_r[1] <= pwdata[COORD_WIDTH-1:0];
        REG_BOX_MIN_Z: box_min_r[2] <= pwdata[COORD_WIDTH-1:0];
        REG_BOX_MAX_X: box_max_r[0] <= pwdata[COORD_WIDTH-1:0];
        REG_BOX_MAX_Y: box_max_r[1] <= pwdata[COORD_WIDTH-1:0];
        REG_BOX_MAX_Z: box_max_r[2] <= pwdata[COORD_WIDTH-1:0];
        REG_HIT_EPS:   eps_r        <= pwdata[EPS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BOX_MIN_X: prdata = CFG_DW'(mag_t'(box_min_r[0]));
      REG_BOX_MIN_Y: prdata = CFG_DW'(mag_t'(box_min_r[1]));
      REG_BOX_MIN_Z: prdata = CFG_DW'(mag_t'(box_min_r[2]));
      REG_BOX_MAX_X: prdata = CFG_DW'(mag_t'(box_max_r[0]));
      REG_BOX_MAX_Y: prdata = CFG_DW'(mag_t'(box_max_r[1]));
      REG_BOX_MAX_Z: prdata = CFG_DW'(mag_t'(box_max_r[2]));
      REG_HIT_EPS:   prdata = CFG_DW'(eps_r);
      default:       prdata = '0;
    endcase
  end

  logic                      prep_valid;
  prep_axis_t [NUM_AXES-1:0] prep_axis;

  rbs_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .take_i    (start && !busy),
    .word_i    (in_word),
    .box_min_i (box_min_r),
    .box_max_i (box_max_r),
    .valid_o   (prep_valid),
    .axis_o    (prep_axis)
  );

  coord_t [NUM_AXES-1:0] t_ent;
  coord_t [NUM_AXES-1:0] t_ext;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    rbs_divider u_div_ent (
      .clk   (clk),
      .n_i   (prep_axis[a].n_ent),
      .m_i   (prep_axis[a].m),
      .neg_i (prep_axis[a].neg_ent),
      .q_o   (t_ent[a])
    );
    rbs_divider u_div_ext (
      .clk   (clk),
      .n_i   (prep_axis[a].n_ext),
      .m_i   (prep_axis[a].m),
      .neg_i (prep_axis[a].neg_ext),
      .q_o   (t_ext[a])
    );
  end

  // control line alongside the divider stages
  side_t side_r [DIV_STAGES];
  side_t side_nxt;

  always_comb begin
    side_nxt.valid = prep_valid;
    for (int a = 0; a < NUM_AXES; a++) begin
      side_nxt.dzero[a]   = prep_axis[a].dzero;
      side_nxt.in_slab[a] = prep_axis[a].in_slab;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        side_r[s] <= '0;
      end
    end else begin
      side_r[0] <= side_nxt;
      for (int s = 1; s < DIV_STAGES; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  rbs_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .side_i   (side_r[DIV_STAGES-1]),
    .ent_i    (t_ent),
    .ext_i    (t_ext),
    .eps_i    (eps_r),
    .strobe_o (out_strobe),
    .word_o   (out_word)
  );

  localparam int LATENCY = DIV_STAGES + 3;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_strobe)
    else $error("word did not come out after the pipeline latency");

  a_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LATENCY))
    else $error("result word without an accepted ray");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_word.hit_flag) |->
      (out_word.t_enter_out == '0 && out_word.t_exit_out == '0))
    else $error("miss carries non-zero parameters");

  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.hit_flag) |->
      (out_word.t_enter_out < out_word.t_exit_out))
    else $error("hit with entry not before exit");

endmodule

// ===== hw/rtl/rbs_prep.sv =====
module rbs_prep import rbs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      take_i,
  input  in_word_t                  word_i,
  input  coord_t [NUM_AXES-1:0]     box_min_i,
  input  coord_t [NUM_AXES-1:0]     box_max_i,
  output logic                      valid_o,
  output prep_axis_t [NUM_AXES-1:0] axis_o
);

  coord_t [NUM_AXES-1:0]     orig;
  coord_t [NUM_AXES-1:0]     dir;
  prep_axis_t [NUM_AXES-1:0] axis_nxt;
  prep_axis_t [NUM_AXES-1:0] axis_r;
  logic                      valid_r;

  assign orig[0] = word_i.origin_x;
  assign orig[1] = word_i.origin_y;
  assign orig[2] = word_i.origin_z;
  assign dir[0]  = word_i.dir_x;
  assign dir[1]  = word_i.dir_y;
  assign dir[2]  = word_i.dir_z;

  always_comb begin
    logic signed [COORD_WIDTH:0] dlo;
    logic signed [COORD_WIDTH:0] dhi;
    logic signed [COORD_WIDTH:0] ent;
    logic signed [COORD_WIDTH:0] ext;
    logic signed [COORD_WIDTH:0] ent_abs;
    logic signed [COORD_WIDTH:0] ext_abs;
    logic signed [COORD_WIDTH:0] d_abs;
    logic                        dneg;
    for (int a = 0; a < NUM_AXES; a++) begin
      // differences at one extra bit so they never wrap
      dlo  = {box_min_i[a][COORD_WIDTH-1], box_min_i[a]} - {orig[a][COORD_WIDTH-1], orig[a]};
      dhi  = {box_max_i[a][COORD_WIDTH-1], box_max_i[a]} - {orig[a][COORD_WIDTH-1], orig[a]};
      dneg = dir[a][COORD_WIDTH-1];
      ent  = dneg ? dhi : dlo;
      ext  = dneg ? dlo : dhi;
      ent_abs = ent[COORD_WIDTH] ? -ent : ent;
      ext_abs = ext[COORD_WIDTH] ? -ext : ext;
      d_abs   = dneg ? -{dir[a][COORD_WIDTH-1], dir[a]} : {dir[a][COORD_WIDTH-1], dir[a]};
      axis_nxt[a].n_ent   = ent_abs[COORD_WIDTH-1:0];
      axis_nxt[a].n_ext   = ext_abs[COORD_WIDTH-1:0];
      axis_nxt[a].m       = d_abs[COORD_WIDTH-1:0];
      axis_nxt[a].neg_ent = ent[COORD_WIDTH] ^ dneg;
      axis_nxt[a].neg_ext = ext[COORD_WIDTH] ^ dneg;
      axis_nxt[a].dzero   = (dir[a] == '0);
      axis_nxt[a].in_slab = (orig[a] >= box_min_i[a]) && (orig[a] <= box_max_i[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= take_i;
    end
  end

  always_ff @(posedge clk) begin
    axis_r <= axis_nxt;
  end

  assign valid_o = valid_r;
  assign axis_o  = axis_r;

endmodule

// ===== hw/rtl/rbs_divider.sv =====
module rbs_divider import rbs_pkg::*; (
  input  logic   clk,
  input  mag_t   n_i,
  input  mag_t   m_i,
  input  logic   neg_i,
  output coord_t q_o
);

  // stage s holds the state after s quotient bits
  mag_t                  rem_st [DIV_STAGES+1];
  logic [DIVD_WIDTH-1:0] divd_st[DIV_STAGES+1];
  mag_t                  quo_st [DIV_STAGES+1];
  logic                  ovf_st [DIV_STAGES+1];
  mag_t                  m_st   [DIV_STAGES+1];
  logic                  neg_st [DIV_STAGES+1];

  assign rem_st[0]  = '0;
  assign divd_st[0] = {n_i, {FRAC_BITS{1'b0}}};
  assign quo_st[0]  = '0;
  assign ovf_st[0]  = 1'b0;
  assign m_st[0]    = m_i;
  assign neg_st[0]  = neg_i;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_step
    logic [COORD_WIDTH:0] trial;
    logic [COORD_WIDTH:0] diff;
    logic                 ge;

    always_comb begin
      trial = {rem_st[s], divd_st[s][DIVD_WIDTH-1]};
      diff  = trial - {1'b0, m_st[s]};
      ge    = (trial >= {1'b0, m_st[s]});
    end

    always_ff @(posedge clk) begin
      rem_st[s+1]  <= ge ? diff[COORD_WIDTH-1:0] : trial[COORD_WIDTH-1:0];
      divd_st[s+1] <= {divd_st[s][DIVD_WIDTH-2:0], 1'b0};
      quo_st[s+1]  <= {quo_st[s][COORD_WIDTH-2:0], ge};
      // any quotient bit at or above the sign position means saturation
      ovf_st[s+1]  <= ovf_st[s] | quo_st[s][COORD_WIDTH-1];
      m_st[s+1]    <= m_st[s];
      neg_st[s+1]  <= neg_st[s];
    end
  end

  logic   ovf;
  coord_t quo;

  always_comb begin
    ovf = ovf_st[DIV_STAGES] | quo_st[DIV_STAGES][COORD_WIDTH-1];
    quo = coord_t'(quo_st[DIV_STAGES]);
    if (ovf) begin
      q_o = neg_st[DIV_STAGES] ? T_MIN : T_MAX;
    end else begin
      q_o = neg_st[DIV_STAGES] ? -quo : quo;
    end
  end

endmodule

// ===== hw/rtl/rbs_reduce.sv =====
module rbs_reduce import rbs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  side_t                 side_i,
  input  coord_t [NUM_AXES-1:0] ent_i,
  input  coord_t [NUM_AXES-1:0] ext_i,
  input  logic [EPS_WIDTH-1:0]  eps_i,
  output logic                  strobe_o,
  output out_word_t             word_o
);

  coord_t [NUM_AXES-1:0] ta_nxt;
  coord_t [NUM_AXES-1:0] tb_nxt;
  coord_t [NUM_AXES-1:0] ta_r;
  coord_t [NUM_AXES-1:0] tb_r;
  logic                  miss_r;
  logic                  valid_r;
  logic                  strobe_r;
  out_word_t             word_r;
  out_word_t             word_nxt;

  // flat axes give an unbounded slab
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      ta_nxt[a] = side_i.dzero[a] ? T_MIN : ent_i[a];
      tb_nxt[a] = side_i.dzero[a] ? T_MAX : ext_i[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      valid_r  <= side_i.valid;
      strobe_r <= valid_r;
    end
  end

  always_ff @(posedge clk) begin
    ta_r   <= ta_nxt;
    tb_r   <= tb_nxt;
    miss_r <= |(side_i.dzero & ~side_i.in_slab);
    word_r <= word_nxt;
  end

  always_comb begin
    coord_t                      t0;
    coord_t                      t1;
    logic signed [COORD_WIDTH:0] t1_w;
    logic signed [COORD_WIDTH:0] eps_w;
    logic                        hit;
    t0 = ta_r[0];
    t1 = tb_r[0];
    for (int a = 1; a < NUM_AXES; a++) begin
      if (ta_r[a] > t0) begin
        t0 = ta_r[a];
      end
      if (tb_r[a] < t1) begin
        t1 = tb_r[a];
      end
    end
    t1_w  = {t1[COORD_WIDTH-1], t1};
    eps_w = {{(COORD_WIDTH+1-EPS_WIDTH){1'b0}}, eps_i};
    hit   = !miss_r && (t0 < t1) && (t1_w > eps_w);
    word_nxt.hit_flag    = hit;
    word_nxt.t_enter_out = hit ? t0 : '0;
    word_nxt.t_exit_out  = hit ? t1 : '0;
  end

  assign strobe_o = strobe_r;
  assign word_o   = word_r;

endmodule

// ===== dv/tb.sv =====
module tb;
  import rbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_word_t           in_word;
  logic               out_strobe;
  out_word_t          out_word;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [CFG_DW-1:0]  pwdata;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;

  ray_box_slab_intersect u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow of the box registers
  longint    box_lo [NUM_AXES];
  longint    box_hi [NUM_AXES];
  longint    eps_val;
  out_word_t hit_q[$];
  int        n_errors;
  int        idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    n_errors++;
  endtask

  // exact quotient truncated to FRAC_BITS, saturated
  function automatic longint slab_div(longint num, longint den);
    bit                  neg;
    longint unsigned     n;
    longint unsigned     m;
    longint unsigned     q;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    m = (den < 0) ? -den : den;
    q = (n << FRAC_BITS) / m;
    if (q >= (64'd1 << (COORD_WIDTH-1))) return neg ? longint'(T_MIN) : longint'(T_MAX);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic out_word_t slab_test(in_word_t w);
    longint    t_in;
    longint    t_out;
    longint    o, d, ta, tb;
    bit        missed;
    out_word_t r;
    coord_t    org [NUM_AXES];
    coord_t    dir [NUM_AXES];
    org = '{w.origin_x, w.origin_y, w.origin_z};
    dir = '{w.dir_x, w.dir_y, w.dir_z};
    t_in = T_MIN;
    t_out = T_MAX;
    missed = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      o = org[a];
      d = dir[a];
      if (d == 0) begin
        if (o < box_lo[a] || o > box_hi[a]) missed = 1'b1;
        ta = T_MIN;
        tb = T_MAX;
      end else if (d > 0) begin
        ta = slab_div(box_lo[a] - o, d);
        tb = slab_div(box_hi[a] - o, d);
      end else begin
        ta = slab_div(box_hi[a] - o, d);
        tb = slab_div(box_lo[a] - o, d);
      end
      if (ta > t_in) t_in = ta;
      if (tb < t_out) t_out = tb;
    end
    r = '0;
    if (!missed && t_in < t_out && t_out > eps_val) begin
      r.hit_flag = 1'b1;
      r.t_enter_out = coord_t'(t_in);
      r.t_exit_out = coord_t'(t_out);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_strobe) begin
      if (hit_q.size() == 0) begin
        report("result word with nothing outstanding");
      end else begin
        exp_w = hit_q.pop_front();
        if (out_word.hit_flag !== exp_w.hit_flag)
          report($sformatf("hit_flag %b, wanted %b", out_word.hit_flag, exp_w.hit_flag));
        if (out_word.t_enter_out !== exp_w.t_enter_out)
          report($sformatf("t_enter %h, wanted %h", out_word.t_enter_out, exp_w.t_enter_out));
        if (out_word.t_exit_out !== exp_w.t_exit_out)
          report($sformatf("t_exit %h, wanted %h", out_word.t_exit_out, exp_w.t_exit_out));
      end
    end
  end

  task automatic send_ray(in_word_t w);
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    hit_q.push_back(slab_test(w));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // wait for the pipeline to empty before touching registers
  task automatic drain();
    start <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk);
    repeat (COORD_WIDTH + FRAC_BITS + 8) @(posedge clk);
  endtask

  task automatic reg_write(int idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx << REG_SHIFT);
    pwdata <= CFG_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (idx < 3) box_lo[idx] = longint'(coord_t'(v));
    else if (idx < 6) box_hi[idx-3] = longint'(coord_t'(v));
    else if (idx == 6) eps_val = v[EPS_WIDTH-1:0];
  endtask

  task automatic set_box(coord_t lx, coord_t ly, coord_t lz, coord_t hx, coord_t hy,
                         coord_t hz, logic [15:0] e);
    reg_write(REG_BOX_MIN_X, lx);
    reg_write(REG_BOX_MIN_Y, ly);
    reg_write(REG_BOX_MIN_Z, lz);
    reg_write(REG_BOX_MAX_X, hx);
    reg_write(REG_BOX_MAX_Y, hy);
    reg_write(REG_BOX_MAX_Z, hz);
    reg_write(REG_HIT_EPS, e);
  endtask

  function automatic coord_t any_coord();
    case ($urandom_range(5))
      0: return T_MIN;
      1: return T_MAX;
      2: return '0;
      3: return coord_t'($signed($urandom_range(40)) - 20) <<< FRAC_BITS;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic in_word_t any_ray();
    in_word_t w;
    w = '{any_coord(), any_coord(), any_coord(), any_coord(), any_coord(), any_coord()};
    return w;
  endfunction

  // ray aimed through a point of the box, origin some steps back along it
  function automatic in_word_t aimed_ray();
    in_word_t w;
    longint   tgt, d, o, s;
    coord_t   org [NUM_AXES];
    coord_t   dir [NUM_AXES];
    s = $urandom_range(8);
    for (int a = 0; a < NUM_AXES; a++) begin
      tgt = box_lo[a] + (box_hi[a] > box_lo[a] ?
            longint'($urandom) % (box_hi[a] - box_lo[a] + 1) : 0);
      d = ($urandom_range(3) == 0) ? 0 : longint'($signed($urandom_range(1 << 19))) - (1 << 18);
      o = tgt - d * s + longint'($urandom_range(255)) - 128;
      if (o > T_MAX) o = T_MAX;
      if (o < T_MIN) o = T_MIN;
      org[a] = coord_t'(o);
      dir[a] = coord_t'(d);
    end
    w = '{org[0], org[1], org[2], dir[0], dir[1], dir[2]};
    return w;
  endfunction

  task automatic random_box();
    coord_t lo [NUM_AXES];
    coord_t hi [NUM_AXES];
    for (int a = 0; a < NUM_AXES; a++) begin
      lo[a] = coord_t'($signed($urandom_range(1 << 22)) - (1 << 21));
      hi[a] = lo[a] + coord_t'($urandom_range(1 << 21));
    end
    set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], 16'($urandom));
  endtask

  task automatic test_reset_box();
    // zero-size box at the origin, reset epsilon
    send_ray('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    send_ray('{-32'sh10000, 32'sd0, 32'sd0, 32'sh10000, 32'sd0, 32'sd0});
    send_ray('{32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    drain();
  endtask

  task automatic test_directed();
    set_box(-32'sh10000, -32'sh10000, -32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000, 16'd7);
    // plain hit along x, then negative direction
    send_ray('{-32'sh50000, 32'sd0, 32'sd0, 32'sh10000, 32'sd0, 32'sd0});
    send_ray('{32'sh50000, 32'sd0, 32'sd0, -32'sh10000, 32'sd0, 32'sd0});
    // zero direction outside its slab misses
    send_ray('{-32'sh50000, 32'sh20000, 32'sd0, 32'sh10000, 32'sd0, 32'sd0});
    // all axes zero, origin in the box: unbounded parameters
    send_ray('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    // box behind the ray
    send_ray('{32'sh50000, 32'sd0, 32'sd0, 32'sh10000, 32'sd0, 32'sd0});
    // tiny direction saturates, huge direction gives small parameters
    send_ray('{-32'sh50000, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0});
    send_ray('{-32'sh50000, 32'sd0, 32'sd0, T_MAX, 32'sd0, 32'sd0});
    send_ray('{T_MIN, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX});
    send_ray('{T_MAX, T_MAX, T_MAX, T_MIN, T_MIN, T_MIN});
    send_ray('{T_MIN, T_MAX, T_MIN, -32'sd1, 32'sd1, T_MIN});
    // exit just at epsilon
    send_ray('{32'sh10000 - 32'sd7, 32'sd0, 32'sd0, 32'sh10000, 32'sd0, 32'sd0});
    send_ray('{32'sh10000 - 32'sd8, 32'sd0, 32'sd0, 32'sh10000, 32'sd0, 32'sd0});
    drain();
    // widest box, extreme epsilon values
    set_box(T_MIN, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX, 16'hffff);
    send_ray('{T_MAX, T_MIN, 32'sd0, -32'sd1, 32'sd1, 32'sd0});
    send_ray('{32'sd0, 32'sd0, 32'sd0, 32'sh10000, -32'sh10000, 32'sd1});
    drain();
    reg_write(REG_HIT_EPS, 32'd0);
    send_ray('{32'sd0, 32'sd0, 32'sd0, 32'sh10000, 32'sd0, 32'sd0});
    drain();
    // inverted box, and a write beyond the last register
    set_box(32'sh10000, 32'sh10000, 32'sh10000, -32'sh10000, -32'sh10000, -32'sh10000, 16'd7);
    reg_write(7, 32'hdeadbeef);
    send_ray('{-32'sh50000, -32'sh50000, -32'sh50000, 32'sh10000, 32'sh10000, 32'sh10000});
    send_ray('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    drain();
  endtask

  task automatic test_random(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 120 == 0) begin
        drain();
        if (i % 480 == 240)
          set_box(T_MIN, T_MIN, T_MIN, T_MAX, T_MAX, T_MAX, 16'($urandom));
        else
          random_box();
      end
      if ($urandom_range(99) < 75) send_ray(aimed_ray());
      else send_ray(any_ray());
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    n_errors = 0;
    idle_pct = 10;
    for (int a = 0; a < NUM_AXES; a++) begin
      box_lo[a] = 0;
      box_hi[a] = 0;
    end
    eps_val = EPS_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_box();
    test_directed();
    idle_pct = 10;
    test_random(480);
    idle_pct = 83;
    test_random(480);
    idle_pct = 0;
    test_random(480);
    if (n_errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rbs_pkg.sv
hw/rtl/rbs_prep.sv
hw/rtl/rbs_divider.sv
hw/rtl/rbs_reduce.sv
hw/rtl/ray_box_slab_intersect.sv
dv/tb.sv
